// File: src/station_address_table_with_aging_core_macros.svh
// assertion macros shared by the station table checker
// no dependencies; included by the checker file
`ifndef STATION_ADDRESS_TABLE_WITH_AGING_CORE_MACROS_SVH
`define STATION_ADDRESS_TABLE_WITH_AGING_CORE_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define SATA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("station table check failed");

// next-cycle implication under synchronous active-low reset
`define SATA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("station table check failed");

`endif

// File: src/sata_pkg.sv
// shared types and constants of the station address table
// used by the controller, datapath, top level and checker
package sata_pkg;

  localparam int MAC_W     = 48;
  localparam int SIG_W     = 8;
  localparam int TIME_W    = 32;
  localparam int LEN_W     = 12;
  localparam int IDX_W     = 8;
  localparam int CNT_OUT_W = 9;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 3;
  localparam int ENTRY_W   = MAC_W + SIG_W + TIME_W;

  localparam int MIN_FRAME_LEN = 24;

  localparam int IN_FIELDS_W  = 3 * MAC_W + LEN_W + SIG_W + TIME_W + IDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = MAC_W + SIG_W + TIME_W + 2 * CNT_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = MAC_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TARGET  = 2'd0,
    CFG_AGE     = 2'd1,
    CFG_LISTEN  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_FRAME = 2'd0,
    OP_SWEEP = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_IGNORED  = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_SWEEP    = 3'd4,
    ST_ENTRY    = 3'd5,
    ST_INVALID  = 3'd6
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    scan_init;
    logic    scan_run;
    logic    upd_wr;
    logic    ins_wr;
    logic    sweep_fin;
    logic    rd_issue;
    logic    set_res;
    status_t res_kind;
    logic    push;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    ignore;
    logic    idx_ok;
    logic    match;
    logic    scan_done;
    logic    full;
    logic    out_free;
  } sts_t;

endpackage

// File: src/sata_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sata_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/sata_ctrl.sv
// sequencer of the station table: decodes each item and steps the table scan
// depends on sata_pkg
module sata_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sata_pkg::sts_t sts,
  output sata_pkg::cmd_t cmd
);
  import sata_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RDWAIT,
    S_PUSH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.opcode)
          OP_FRAME: begin
            if (sts.ignore) begin
              cmd.set_res  = 1'b1;
              cmd.res_kind = ST_IGNORED;
              state_nxt    = S_PUSH;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          OP_SWEEP: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          OP_READ: begin
            if (sts.idx_ok) begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RDWAIT;
            end else begin
              cmd.set_res  = 1'b1;
              cmd.res_kind = ST_INVALID;
              state_nxt    = S_PUSH;
            end
          end
          OP_RSVD: begin
            cmd.set_res  = 1'b1;
            cmd.res_kind = ST_IGNORED;
            state_nxt    = S_PUSH;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.opcode == OP_SWEEP) begin
          cmd.scan_run = 1'b1;
          if (sts.scan_done) begin
            cmd.sweep_fin = 1'b1;
            cmd.set_res   = 1'b1;
            cmd.res_kind  = ST_SWEEP;
            state_nxt     = S_PUSH;
          end
        end else if (sts.match) begin
          // known station: refresh it in place
          cmd.upd_wr   = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_kind = ST_UPDATED;
          state_nxt    = S_PUSH;
        end else if (sts.scan_done) begin
          cmd.set_res = 1'b1;
          if (sts.full) begin
            cmd.res_kind = ST_FULL;
          end else begin
            cmd.ins_wr   = 1'b1;
            cmd.res_kind = ST_INSERTED;
          end
          state_nxt = S_PUSH;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd.set_res  = 1'b1;
        cmd.res_kind = ST_ENTRY;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/sata_dp.sv
// datapath of the station table: item and config registers, table ram,
// scan pointers, compare logic and the result and output registers
// depends on sata_pkg and sata_ram
module sata_dp #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sata_pkg::cmd_t                     cmd,
  output sata_pkg::sts_t                     sts,
  input  sata_pkg::opcode_t                  item_opcode,
  input  logic [sata_pkg::MAC_W-1:0]         item_addr_one,
  input  logic [sata_pkg::MAC_W-1:0]         item_addr_two,
  input  logic [sata_pkg::MAC_W-1:0]         item_addr_three,
  input  logic [sata_pkg::LEN_W-1:0]         item_frame_length,
  input  logic signed [sata_pkg::SIG_W-1:0]  item_signal_strength,
  input  logic [sata_pkg::TIME_W-1:0]        item_now_ms,
  input  logic [sata_pkg::IDX_W-1:0]         item_entry_index,
  input  logic                               cfg_we,
  input  logic [sata_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sata_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               res_valid,
  input  logic                               res_ready,
  output sata_pkg::status_t                  res_status,
  output logic [sata_pkg::MAC_W-1:0]         res_station_mac,
  output logic signed [sata_pkg::SIG_W-1:0]  res_entry_signal,
  output logic [sata_pkg::TIME_W-1:0]        res_entry_time,
  output logic [sata_pkg::CNT_OUT_W-1:0]     res_station_count,
  output logic [sata_pkg::CNT_OUT_W-1:0]     res_removed_count
);
  import sata_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // config registers
  logic [MAC_W-1:0]  target_r;
  logic [TIME_W-1:0] age_limit_r;
  logic              listen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      age_limit_r <= TIME_W'(30000);
      listen_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TARGET: target_r    <= cfg_wdata;
        CFG_AGE:    age_limit_r <= cfg_wdata[TIME_W-1:0];
        CFG_LISTEN: listen_r    <= cfg_wdata[0];
        CFG_UNUSED: ;
        default:    ;
      endcase
    end
  end

  // captured item
  opcode_t                  opcode_r;
  logic [MAC_W-1:0]         a1_r, a2_r, a3_r;
  logic [LEN_W-1:0]         len_r;
  logic signed [SIG_W-1:0]  sig_r;
  logic [TIME_W-1:0]        now_r;
  logic [IDX_W-1:0]         idx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r <= item_opcode;
      a1_r     <= item_addr_one;
      a2_r     <= item_addr_two;
      a3_r     <= item_addr_three;
      len_r    <= item_frame_length;
      sig_r    <= item_signal_strength;
      now_r    <= item_now_ms;
      idx_r    <= item_entry_index;
    end
  end

  // frame filter and station pick
  logic             a1_tgt, a2_tgt, a3_tgt, ignore;
  logic [MAC_W-1:0] sta_nxt;

  assign a1_tgt  = (a1_r == target_r);
  assign a2_tgt  = (a2_r == target_r);
  assign a3_tgt  = (a3_r == target_r);
  assign ignore  = !listen_r || (len_r < LEN_W'(MIN_FRAME_LEN)) ||
                   !(a1_tgt || a2_tgt || a3_tgt) || (a1_tgt && a2_tgt);
  assign sta_nxt = a1_tgt ? a2_r : a1_r;

  // table state and scan pointers
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    rd_ptr_r;
  logic [CW-1:0]    wr_ptr_r;
  logic [CW-1:0]    removed_r;
  logic             pend_r;
  logic [AW-1:0]    pend_idx_r;
  logic [MAC_W-1:0] sta_r;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [MAC_W-1:0]   rd_mac;
  logic [SIG_W-1:0]   rd_sig;
  logic [TIME_W-1:0]  rd_time;
  logic [TIME_W-1:0]  rd_age;
  logic               stale, scan_issue, sweep_copy, idx_ok;

  assign rd_mac  = ram_rdata[MAC_W-1:0];
  assign rd_sig  = ram_rdata[MAC_W +: SIG_W];
  assign rd_time = ram_rdata[MAC_W + SIG_W +: TIME_W];
  assign rd_age  = now_r - rd_time;
  assign stale   = (rd_age > age_limit_r);

  assign scan_issue = cmd.scan_run && (rd_ptr_r < count_r);
  assign sweep_copy = cmd.scan_run && pend_r && (opcode_r == OP_SWEEP) && !stale;
  assign idx_ok     = ({1'b0, idx_r} < CNT_OUT_W'(count_r));

  assign ram_re    = scan_issue || cmd.rd_issue;
  assign ram_raddr = cmd.rd_issue ? idx_r[AW-1:0] : rd_ptr_r[AW-1:0];
  assign ram_we    = cmd.upd_wr || cmd.ins_wr || sweep_copy;

  always_comb begin
    ram_waddr = wr_ptr_r[AW-1:0];
    ram_wdata = ram_rdata;
    if (cmd.upd_wr) begin
      ram_waddr = pend_idx_r;
      ram_wdata = {now_r, sig_r, sta_r};
    end else if (cmd.ins_wr) begin
      ram_waddr = count_r[AW-1:0];
      ram_wdata = {now_r, sig_r, sta_r};
    end
  end

  sata_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        pend_r <= 1'b0;
      end else if (cmd.scan_run) begin
        pend_r <= scan_issue;
      end
      if (cmd.ins_wr) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.sweep_fin) begin
        count_r <= wr_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      removed_r <= '0;
      sta_r     <= sta_nxt;
    end else if (cmd.scan_run) begin
      if (scan_issue) begin
        rd_ptr_r   <= rd_ptr_r + 1'b1;
        pend_idx_r <= rd_ptr_r[AW-1:0];
      end
      if (sweep_copy) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end else if (pend_r && (opcode_r == OP_SWEEP)) begin
        removed_r <= removed_r + 1'b1;
      end
    end
  end

  assign sts.opcode    = opcode_r;
  assign sts.ignore    = ignore;
  assign sts.idx_ok    = idx_ok;
  assign sts.match     = pend_r && (rd_mac == sta_r);
  assign sts.scan_done = !pend_r && (rd_ptr_r == count_r);
  assign sts.full      = (count_r == CW'(TABLE_DEPTH));
  assign sts.out_free  = !res_valid || res_ready;

  // pending result, then output register
  status_t                 pr_status_r;
  logic [MAC_W-1:0]        pr_mac_r;
  logic signed [SIG_W-1:0] pr_sig_r;
  logic [TIME_W-1:0]       pr_time_r;
  logic [CNT_OUT_W-1:0]    pr_removed_r;
  logic [MAC_W-1:0]        pr_mac_nxt;
  logic signed [SIG_W-1:0] pr_sig_nxt;
  logic [TIME_W-1:0]       pr_time_nxt;
  logic [CNT_OUT_W-1:0]    pr_removed_nxt;

  always_comb begin
    pr_mac_nxt     = '0;
    pr_sig_nxt     = '0;
    pr_time_nxt    = '0;
    pr_removed_nxt = '0;
    unique case (cmd.res_kind)
      ST_UPDATED, ST_INSERTED: begin
        pr_mac_nxt  = sta_r;
        pr_sig_nxt  = sig_r;
        pr_time_nxt = now_r;
      end
      ST_FULL: begin
        pr_mac_nxt = sta_r;
      end
      ST_SWEEP: begin
        pr_removed_nxt = CNT_OUT_W'(removed_r);
      end
      ST_ENTRY: begin
        pr_mac_nxt  = rd_mac;
        pr_sig_nxt  = rd_sig;
        pr_time_nxt = rd_time;
      end
      ST_IGNORED, ST_INVALID: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      pr_status_r  <= cmd.res_kind;
      pr_mac_r     <= pr_mac_nxt;
      pr_sig_r     <= pr_sig_nxt;
      pr_time_r    <= pr_time_nxt;
      pr_removed_r <= pr_removed_nxt;
    end
  end

  logic res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.push) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res_status        <= pr_status_r;
      res_station_mac   <= pr_mac_r;
      res_entry_signal  <= pr_sig_r;
      res_entry_time    <= pr_time_r;
      res_station_count <= CNT_OUT_W'(count_r);
      res_removed_count <= pr_removed_r;
    end
  end

  assign res_valid = res_valid_r;

endmodule

// File: src/station_address_table_with_aging_core.sv
// Station address table with aging. Each input beat is a captured frame, an age sweep, a
// read of one table entry or a reserved opcode (selected by in_tuser) and gives exactly
// one result beat. A frame or a sweep walks the valid entries through the single read
// port of the table ram, one entry a cycle; a frame stops at a matching entry. The result
// beat appears in the same cycle in which the next beat can be accepted, later while a
// previous result waits for out_tready. The block takes one item at a time; a finished
// result sits in the output register while the next item is accepted.
// Table contents are not cleared at reset: only the first station_count entries are valid.
// Configuration must be written through cfg_we/cfg_addr/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
// depends on sata_pkg, sata_ctrl, sata_dp and sata_ram
module station_address_table_with_aging_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // addr_one, addr_two, addr_three, frame_length, signal_strength, now_ms, entry_index
  input  logic [sata_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode
  input  logic [sata_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // station_mac, entry_signal, entry_time, station_count, removed_count
  output logic [sata_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status
  output logic [sata_pkg::STAT_W-1:0]         out_tuser,
  input  logic                                cfg_we,
  input  logic [sata_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sata_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sata_pkg::*;

  localparam int A1_LSB  = 0;
  localparam int A2_LSB  = A1_LSB + MAC_W;
  localparam int A3_LSB  = A2_LSB + MAC_W;
  localparam int LEN_LSB = A3_LSB + MAC_W;
  localparam int SIG_LSB = LEN_LSB + LEN_W;
  localparam int NOW_LSB = SIG_LSB + SIG_W;
  localparam int IDX_LSB = NOW_LSB + TIME_W;

  cmd_t cmd;
  sts_t sts;

  status_t                 res_status;
  logic [MAC_W-1:0]        res_mac;
  logic signed [SIG_W-1:0] res_sig;
  logic [TIME_W-1:0]       res_time;
  logic [CNT_OUT_W-1:0]    res_count;
  logic [CNT_OUT_W-1:0]    res_removed;

  sata_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sata_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .item_opcode          (opcode_t'(in_tuser)),
    .item_addr_one        (in_tdata[A1_LSB +: MAC_W]),
    .item_addr_two        (in_tdata[A2_LSB +: MAC_W]),
    .item_addr_three      (in_tdata[A3_LSB +: MAC_W]),
    .item_frame_length    (in_tdata[LEN_LSB +: LEN_W]),
    .item_signal_strength (in_tdata[SIG_LSB +: SIG_W]),
    .item_now_ms          (in_tdata[NOW_LSB +: TIME_W]),
    .item_entry_index     (in_tdata[IDX_LSB +: IDX_W]),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .res_valid            (out_tvalid),
    .res_ready            (out_tready),
    .res_status           (res_status),
    .res_station_mac      (res_mac),
    .res_entry_signal     (res_sig),
    .res_entry_time       (res_time),
    .res_station_count    (res_count),
    .res_removed_count    (res_removed)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res_removed, res_count,
                      res_time, res_sig, res_mac};
  assign out_tuser = res_status;

endmodule

// File: src/sata_checker.sv
// port-level checks of the station address table, bound to the top level
// depends on sata_pkg and the assertion macro header
`include "station_address_table_with_aging_core_macros.svh"

module sata_port_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sata_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [sata_pkg::STAT_W-1:0]      out_tuser
);
  import sata_pkg::*;

  localparam int CNT_LSB = MAC_W + SIG_W + TIME_W;
  localparam int REM_LSB = CNT_LSB + CNT_OUT_W;

  logic [CNT_OUT_W-1:0] count_seen;
  logic [CNT_OUT_W-1:0] removed_seen;
  logic [MAC_W-1:0]     mac_seen;
  logic                 other_beat;
  logic                 no_sta_beat;

  assign count_seen   = out_tdata[CNT_LSB +: CNT_OUT_W];
  assign removed_seen = out_tdata[REM_LSB +: CNT_OUT_W];
  assign mac_seen     = out_tdata[MAC_W-1:0];
  assign other_beat   = out_tvalid && (out_tuser != ST_SWEEP);
  assign no_sta_beat  = out_tvalid && (out_tuser == ST_IGNORED || out_tuser == ST_SWEEP ||
                                       out_tuser == ST_INVALID);

  // held result while the sink stalls
  `SATA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // one item in flight: no accept right after an accept
  `SATA_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // the table never reports more stations than it has entries
  `SATA_ASSERT_IMP(a_count_bound, clk, rst_n, out_tvalid, count_seen <= CNT_OUT_W'(TABLE_DEPTH))
  // only a sweep reports removed entries
  `SATA_ASSERT_IMP(a_removed_sweep, clk, rst_n, other_beat, removed_seen == '0)
  // results without a station carry a zero address
  `SATA_ASSERT_IMP(a_zero_mac, clk, rst_n, no_sta_beat, mac_seen == '0)

endmodule

bind station_address_table_with_aging_core sata_port_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_sata_checker (.*);

// File: verif/sata_checker.sv
// result checker for the station address table: watches the input, result and register ports,
// keeps its own copy of the table and compares every result beat with its prediction
// depends on sata_pkg
module sata_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [sata_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [sata_pkg::OP_W-1:0]        in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [sata_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [sata_pkg::STAT_W-1:0]      out_tuser,
  input  logic                             cfg_we,
  input  logic [sata_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sata_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               fail_count,
  output int                               awaited,
  output int                               checked
);
  import sata_pkg::*;

  // input field offsets, lowest bit first
  localparam int A1_LO  = 0;
  localparam int A2_LO  = A1_LO + MAC_W;
  localparam int A3_LO  = A2_LO + MAC_W;
  localparam int LEN_LO = A3_LO + MAC_W;
  localparam int SIG_LO = LEN_LO + LEN_W;
  localparam int NOW_LO = SIG_LO + SIG_W;
  localparam int IDX_LO = NOW_LO + TIME_W;
  // result field offsets
  localparam int MAC_LO  = 0;
  localparam int OSIG_LO = MAC_LO + MAC_W;
  localparam int OTM_LO  = OSIG_LO + SIG_W;
  localparam int CNT_LO  = OTM_LO + TIME_W;
  localparam int REM_LO  = CNT_LO + CNT_OUT_W;

  typedef struct packed {
    status_t                status;
    logic [MAC_W-1:0]       mac;
    logic [SIG_W-1:0]       sig;
    logic [TIME_W-1:0]      tm;
    logic [CNT_OUT_W-1:0]   cnt;
    logic [CNT_OUT_W-1:0]   removed;
  } table_result_t;

  logic [MAC_W-1:0]  sta_mac  [TABLE_DEPTH];
  logic [SIG_W-1:0]  sta_sig  [TABLE_DEPTH];
  logic [TIME_W-1:0] sta_seen [TABLE_DEPTH];
  int                sta_count;

  logic [MAC_W-1:0]  target_net;
  logic [TIME_W-1:0] age_limit;
  logic              listening;

  table_result_t awaited_results[$];

  task automatic predict_table_result(
    input  opcode_t           op,
    input  logic [MAC_W-1:0]  a1,
    input  logic [MAC_W-1:0]  a2,
    input  logic [MAC_W-1:0]  a3,
    input  logic [LEN_W-1:0]  len,
    input  logic [SIG_W-1:0]  sig,
    input  logic [TIME_W-1:0] now,
    input  logic [IDX_W-1:0]  idx,
    output table_result_t     res
  );
    logic [MAC_W-1:0]  sta;
    logic [TIME_W-1:0] age;
    logic              found;
    int                w;
    int                gone;
    res = '0;
    res.status = ST_IGNORED;
    case (op)
      OP_FRAME: begin
        // needs listening on, a long enough frame naming the target, and a station other than the target
        if (listening && len >= MIN_FRAME_LEN &&
            (a1 == target_net || a2 == target_net || a3 == target_net) &&
            !(a1 == target_net && a2 == target_net)) begin
          sta   = (a1 != target_net) ? a1 : a2;
          found = 1'b0;
          for (int i = 0; i < sta_count; i++) begin
            if (!found && sta_mac[i] == sta) begin
              found       = 1'b1;
              sta_sig[i]  = sig;
              sta_seen[i] = now;
            end
          end
          res.mac = sta;
          if (found) begin
            res.status = ST_UPDATED;
            res.sig    = sig;
            res.tm     = now;
          end else if (sta_count < TABLE_DEPTH) begin
            sta_mac[sta_count]  = sta;
            sta_sig[sta_count]  = sig;
            sta_seen[sta_count] = now;
            sta_count++;
            res.status = ST_INSERTED;
            res.sig    = sig;
            res.tm     = now;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      OP_SWEEP: begin
        w    = 0;
        gone = 0;
        for (int r = 0; r < sta_count; r++) begin
          age = now - sta_seen[r];
          if (age > age_limit) begin
            gone++;
          end else begin
            sta_mac[w]  = sta_mac[r];
            sta_sig[w]  = sta_sig[r];
            sta_seen[w] = sta_seen[r];
            w++;
          end
        end
        sta_count   = w;
        res.status  = ST_SWEEP;
        res.removed = CNT_OUT_W'(gone);
      end
      OP_READ: begin
        if (int'(idx) < sta_count) begin
          res.status = ST_ENTRY;
          res.mac    = sta_mac[idx];
          res.sig    = sta_sig[idx];
          res.tm     = sta_seen[idx];
        end else begin
          res.status = ST_INVALID;
        end
      end
      default: res.status = ST_IGNORED;
    endcase
    res.cnt = CNT_OUT_W'(sta_count);
  endtask

  always @(posedge clk) begin : watch
    table_result_t exp_res;
    table_result_t got_res;
    if (!rst_n) begin
      sta_count  = 0;
      target_net = '0;
      age_limit  = 32'd30000;
      listening  = 1'b0;
      fail_count = 0;
      checked    = 0;
      awaited_results.delete();
    end else begin
      // results first: a beat leaving can never belong to a beat entering at the same edge
      if (out_tvalid && out_tready) begin
        got_res.status  = status_t'(out_tuser);
        got_res.mac     = out_tdata[MAC_LO +: MAC_W];
        got_res.sig     = out_tdata[OSIG_LO +: SIG_W];
        got_res.tm      = out_tdata[OTM_LO +: TIME_W];
        got_res.cnt     = out_tdata[CNT_LO +: CNT_OUT_W];
        got_res.removed = out_tdata[REM_LO +: CNT_OUT_W];
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: status %0d mac %h", got_res.status, got_res.mac);
        end else begin
          exp_res = awaited_results.pop_front();
          checked++;
          if (got_res !== exp_res) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d expected: status %0d mac %h sig %0d tm %h cnt %0d rem %0d",
                       checked, exp_res.status, exp_res.mac, $signed(exp_res.sig), exp_res.tm,
                       exp_res.cnt, exp_res.removed);
              $display("result %0d actual:   status %0d mac %h sig %0d tm %h cnt %0d rem %0d",
                       checked, got_res.status, got_res.mac, $signed(got_res.sig), got_res.tm,
                       got_res.cnt, got_res.removed);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_TARGET: target_net = cfg_wdata[MAC_W-1:0];
          CFG_AGE:    age_limit  = cfg_wdata[TIME_W-1:0];
          CFG_LISTEN: listening  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_table_result(opcode_t'(in_tuser), in_tdata[A1_LO +: MAC_W],
                             in_tdata[A2_LO +: MAC_W], in_tdata[A3_LO +: MAC_W],
                             in_tdata[LEN_LO +: LEN_W], in_tdata[SIG_LO +: SIG_W],
                             in_tdata[NOW_LO +: TIME_W], in_tdata[IDX_LO +: IDX_W], exp_res);
        awaited_results.push_back(exp_res);
      end
    end
    awaited = awaited_results.size();
  end

endmodule

// File: verif/tb_top.sv
// testbench top for the station address table: clock, reset, register writes and beats
// on the input channel, random stalls on the result channel and the final verdict
// depends on sata_pkg, sata_checker and station_address_table_with_aging_core
module tb_top;
  import sata_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int POOL_SIZE   = 48;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 320;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int fail_count;
  int awaited;
  int checked;
  int beats_sent;
  int cycles;
  int phase_writes;
  logic no_idle;

  logic [MAC_W-1:0]  target;
  logic [TIME_W-1:0] clock_ms;
  logic [MAC_W-1:0]  stations[POOL_SIZE];

  station_address_table_with_aging_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  sata_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .awaited(awaited), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[MAC_W-1:0];
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // result side stalls
  initial begin : sink
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_tready = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still awaited", cycles, awaited);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(input opcode_t op, input logic [MAC_W-1:0] a1,
                           input logic [MAC_W-1:0] a2, input logic [MAC_W-1:0] a3,
                           input logic [LEN_W-1:0] len, input logic [SIG_W-1:0] sig,
                           input logic [TIME_W-1:0] now, input logic [IDX_W-1:0] idx);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, idx, now, sig, len, a3, a2, a1};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // idle the input channel until every result is in, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    phase_writes++;
  endtask

  task automatic frame(input logic [MAC_W-1:0] a1, input logic [MAC_W-1:0] a2,
                       input logic [MAC_W-1:0] a3, input logic [LEN_W-1:0] len,
                       input logic [SIG_W-1:0] sig, input logic [TIME_W-1:0] now);
    send_beat(OP_FRAME, a1, a2, a3, len, sig, now, '0);
  endtask

  task automatic random_beat();
    int r;
    int pick;
    logic [MAC_W-1:0] a1, a2, a3, sta;
    logic [LEN_W-1:0] len;
    logic [SIG_W-1:0] sig;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 20) clock_ms = clock_ms;
    else if (r < 90) clock_ms = clock_ms + $urandom_range(1, 2000);
    else if (r < 97) clock_ms = clock_ms + $urandom_range(2000, 40000);
    else clock_ms = $urandom();
    a1  = rand_mac();
    a2  = rand_mac();
    a3  = rand_mac();
    sig = SIG_W'($urandom_range(0, 255));
    len = LEN_W'($urandom_range(0, 4095));
    idx = IDX_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      sta  = stations[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0) begin
        len = LEN_W'($urandom_range(MIN_FRAME_LEN, 4095));
        case (pick)
          0: begin a1 = sta; a3 = target; end
          1: begin a1 = target; a2 = sta; end
          default: begin a1 = sta; a2 = target; end
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: ; // addresses unrelated to the target
          1: begin
            a1  = sta;
            a3  = target;
            len = LEN_W'($urandom_range(0, MIN_FRAME_LEN - 1));
          end
          2: begin a1 = target; a2 = target; end
          default: a3 = target; // stranger outside the pool
        endcase
      end
      send_beat(OP_FRAME, a1, a2, a3, len, sig, clock_ms, idx);
    end else if (r < 82) begin
      send_beat(OP_SWEEP, a1, a2, a3, len, sig, clock_ms, idx);
    end else if (r < 95) begin
      if ($urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, TABLE_DEPTH + 1));
      send_beat(OP_READ, a1, a2, a3, len, sig, clock_ms, idx);
    end else begin
      send_beat(OP_RSVD, a1, a2, a3, len, sig, clock_ms, idx);
    end
  endtask

  initial begin : stimulus
    logic [MAC_W-1:0] sta_x, sta_y, ones;
    logic [TIME_W-1:0] age;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    no_idle      = 1'b0;
    beats_sent   = 0;
    phase_writes = 0;
    target       = '0;
    clock_ms     = '0;
    ones         = '1;
    for (int i = 0; i < POOL_SIZE; i++) stations[i] = rand_mac();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset state: listening off, empty table
    frame(rand_mac(), rand_mac(), '0, 12'd100, 8'd10, 32'd5);
    send_beat(OP_SWEEP, '0, '0, '0, '0, '0, 32'd10, '0);
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'd0);
    send_beat(OP_RSVD, ones, ones, ones, '1, '1, '1, '1);
    drain();

    target = 48'h02_1a_11_f0_00_01;
    sta_x  = 48'h8c_aa_b5_12_34_56;
    sta_y  = 48'h3c_71_bf_65_43_21;
    write_reg(CFG_TARGET, target);
    write_reg(CFG_AGE, 48'd1000);
    write_reg(CFG_LISTEN, 48'd1);
    frame(sta_x, rand_mac(), target, 12'd23, 8'd5, 32'd50);        // one byte short
    frame(sta_x, rand_mac(), target, 12'd24, 8'h7f, 32'd100);      // new station
    frame(target, sta_y, '0, 12'hfff, 8'h80, 32'd200);            // station in addr two
    frame(target, target, target, 12'd60, 8'd1, 32'd300);         // no station address
    frame(ones, '0, ones, 12'd60, 8'd2, 32'd400);                 // target absent
    frame(sta_x, '0, target, 12'd80, 8'd0, 32'd900);              // refresh
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'd0);
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'd1);
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'd2);
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'hff);
    frame(ones, target, '0, 12'd100, 8'hff, 32'd1500);
    frame('0, rand_mac(), target, 12'd100, 8'h01, 32'd1600);
    // sweep time behind the newest entries: their age wraps around and they go
    send_beat(OP_SWEEP, '0, '0, '0, '0, '0, 32'd1150, '0);
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'd0);
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'd1);
    // age exactly at the limit survives
    send_beat(OP_SWEEP, '0, '0, '0, '0, '0, 32'd1900, '0);
    send_beat(OP_READ, '0, '0, '0, '0, '0, '0, 8'd0);
    send_beat(OP_SWEEP, ones, ones, ones, '1, '1, 32'hffff_ffff, '1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin target = rand_mac(); age = 32'd5000; end
        1: begin target = '1; age = '0; end
        2: begin target = '0; age = '1; clock_ms = 32'hffff_0000; end
        3: begin target = rand_mac(); age = 32'd30000; end
        default: begin target = rand_mac(); age = $urandom_range(0, 100000); end
      endcase
      write_reg(CFG_TARGET, target);
      write_reg(CFG_AGE, {16'($urandom()), age});
      write_reg(CFG_LISTEN, {47'(rand_mac()), (ph != 3)});
      if (ph == 3) write_reg(CFG_UNUSED, rand_mac());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = ((i % 160) < 32);
        random_beat();
      end
      no_idle = 1'b0;
      drain();
    end

    repeat (50) @(negedge clk);
    $display("sent %0d beats over %0d register writes and %0d random settings", beats_sent,
             phase_writes, PHASES);
    $display("compared %0d results, %0d failures", checked, fail_count);
    if (fail_count == 0 && awaited == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
